// ===== rtl/core/rcz_pkg.sv =====
// package for the rgb 3x3 convolution: constants, types and helpers
package rcz_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int COEF_FRAC_BITS = 8;
    localparam int CFG_WIDTH      = 48;
    localparam int CFG_INDEX_BITS = 3;
    localparam int PIX_BITS       = 24;
    localparam int TAP_BITS       = 16;
    localparam int SUM_BITS       = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_TOP    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_MIDDLE = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_BOTTOM = 3'd4;

    // one column of the window, top to bottom, as it moves down the cell row
    typedef struct packed {
        logic [PIX_BITS-1:0] top;
        logic [PIX_BITS-1:0] mid;
        logic [PIX_BITS-1:0] bot;
    } column_t;

    // tap masks and tag that travel with a result through the pipeline
    typedef struct packed {
        logic       valid;
        logic [2:0] row_ok;
        logic [2:0] col_ok;
        logic       last;
    } tag_t;

    // clamp an exact Q sum to 0..255 with the fraction dropped
    function automatic logic [7:0] clamp_channel(input logic signed [SUM_BITS-1:0] sum,
                                                 input int frac);
        logic [SUM_BITS-1:0] v;
        begin
            v = SUM_BITS'(sum) >> frac;
            if (sum < 0) clamp_channel = 8'd0;
            else if (v > SUM_BITS'(255)) clamp_channel = 8'd255;
            else clamp_channel = v[7:0];
        end
    endfunction

endpackage

// ===== rtl/core/rcz_ram.sv =====
// generic single write, single registered read ram
module rcz_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem_reg[rd_addr];
    end
    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/core/rcz_cell.sv =====
// one window cell: holds one column, multiplies by its three taps
module rcz_cell (
    input  logic                              aclk,
    input  logic                              shift_en,
    input  logic                              mul_en,
    input  rcz_pkg::column_t                  col_in,
    output rcz_pkg::column_t                  col_out,
    input  logic [2:0]                        row_ok,
    input  logic                              col_ok,
    input  logic signed [rcz_pkg::TAP_BITS-1:0] tap_top,
    input  logic signed [rcz_pkg::TAP_BITS-1:0] tap_mid,
    input  logic signed [rcz_pkg::TAP_BITS-1:0] tap_bot,
    output logic signed [rcz_pkg::SUM_BITS-1:0] part_sum [3]
);
    rcz_pkg::column_t col_reg;
    logic signed [rcz_pkg::SUM_BITS-1:0] part_reg [3];
    logic signed [rcz_pkg::SUM_BITS-1:0] part_next [3];

    always_comb begin
        logic signed [rcz_pkg::SUM_BITS-1:0] acc;
        for (int ch = 0; ch < 3; ch++) begin
            acc = '0;
            if (col_ok && row_ok[0])
                acc = acc + $signed({1'b0, col_reg.top[8*ch +: 8]}) * tap_top;
            if (col_ok && row_ok[1])
                acc = acc + $signed({1'b0, col_reg.mid[8*ch +: 8]}) * tap_mid;
            if (col_ok && row_ok[2])
                acc = acc + $signed({1'b0, col_reg.bot[8*ch +: 8]}) * tap_bot;
            part_next[ch] = acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) col_reg <= col_in;
        if (mul_en) part_reg <= part_next;
    end

    assign col_out  = col_reg;
    assign part_sum = part_reg;
endmodule

// ===== rtl/core/rgb_conv3x3_zero_pad.sv =====
// top level of the streaming rgb 3x3 convolution with zero padding
//
//  channel | ports                          | direction | handshake
//  input   | s_red_in s_green_in s_blue_in  | in        | s_valid / s_ready
//          | s_drain                        |           |
//  result  | m_red_out m_green_out          | out       | m_valid / m_ready
//          | m_blue_out m_frame_end         |           |
//  config  | cfg_we cfg_index cfg_data      | in        | write enable only
//
// one transfer per cycle while the result side keeps up; each line store ram
// takes one read and one write per cycle, so nothing else limits the rate
// a result passes these registers in order after the transfer that completes its window:
// ram read at the transfer, window shift, cell multiply, then sum and clamp
// synchronous active-low reset sets config to its defaults and clears counters and valid flags
// the pipeline advances as a whole; a stall at m_ready holds every stage
module rgb_conv3x3_zero_pad #(
    parameter int MAX_WIDTH      = rcz_pkg::MAX_WIDTH,
    parameter int COEF_FRAC_BITS = rcz_pkg::COEF_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [rcz_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rcz_pkg::CFG_WIDTH-1:0]     cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_red_in,
    input  logic [7:0]                        s_green_in,
    input  logic [7:0]                        s_blue_in,
    input  logic                              s_drain,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_red_out,
    output logic [7:0]                        m_green_out,
    output logic [7:0]                        m_blue_out,
    output logic                              m_frame_end
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);

    // configuration registers
    logic [10:0] width_cfg_reg;
    logic [15:0] height_cfg_reg;
    logic [rcz_pkg::CFG_WIDTH-1:0] ktop_reg, kmid_reg, kbot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= 11'd1024;
            height_cfg_reg <= 16'd1024;
            ktop_reg       <= '0;
            kmid_reg       <= 48'h000001000000;
            kbot_reg       <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                rcz_pkg::REG_IMAGE_WIDTH:   width_cfg_reg  <= cfg_data[10:0];
                rcz_pkg::REG_IMAGE_HEIGHT:  height_cfg_reg <= cfg_data[15:0];
                rcz_pkg::REG_KERNEL_TOP:    ktop_reg       <= cfg_data;
                rcz_pkg::REG_KERNEL_MIDDLE: kmid_reg       <= cfg_data;
                rcz_pkg::REG_KERNEL_BOTTOM: kbot_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective geometry, clipped to the usable range
    logic [CW-1:0] w_eff;
    logic [15:0]   h_eff;
    always_comb begin
        if (width_cfg_reg == 11'd0) w_eff = CW'(1);
        else if (32'(width_cfg_reg) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
        else w_eff = CW'(width_cfg_reg);
        h_eff = (height_cfg_reg == 16'd0) ? 16'd1 : height_cfg_reg;
    end

    // pipeline advance: all stages move together unless the result is stuck
    logic adv;
    logic s_fire;
    assign adv    = !m_valid || m_ready;
    assign s_ready = adv;
    assign s_fire = s_valid && s_ready;

    // position counters
    logic [CW-1:0] in_col_reg, out_col_reg;
    logic [16:0]   in_row_reg;
    logic [15:0]   out_row_reg;

    // normalize counters left beyond a shrunk width
    logic [CW-1:0] ic0, oc0;
    logic [16:0]   ir0;
    logic [15:0]   or0;
    always_comb begin
        ic0 = in_col_reg;  ir0 = in_row_reg;
        oc0 = out_col_reg; or0 = out_row_reg;
        if (ic0 >= w_eff) begin
            ic0 = '0;
            if (ir0 != 17'h1FFFF) ir0 = ir0 + 17'd1;
        end
        if (oc0 >= w_eff) begin
            oc0 = '0;
            or0 = or0 + 16'd1;
        end
    end

    logic emit, last;
    logic [CW-1:0] ic1;
    logic [16:0]   ir1;
    logic [CW-1:0] oc1;
    logic [15:0]   or1;
    logic [2:0]    row_ok, col_ok;
    always_comb begin
        emit = (ir0 >= 17'd2) || (ir0 == 17'd1 && ic0 >= CW'(1));
        ic1 = ic0 + CW'(1);
        ir1 = ir0;
        if (ic1 >= w_eff) begin
            ic1 = '0;
            if (ir1 != 17'h1FFFF) ir1 = ir1 + 17'd1;
        end
        last = (17'(or0) + 17'd1 >= 17'(h_eff)) && (oc0 + CW'(1) >= w_eff);
        oc1 = oc0 + CW'(1);
        or1 = or0;
        if (oc1 >= w_eff) begin
            oc1 = '0;
            or1 = or0 + 16'd1;
        end
        row_ok = {17'(or0) + 17'd1 < 17'(h_eff), 1'b1, or0 != 16'd0};
        col_ok = {oc0 + CW'(1) < w_eff, 1'b1, oc0 != '0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (s_fire) begin
            if (emit && last) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else begin
                in_col_reg <= ic1;
                in_row_reg <= ir1;
                if (emit) begin
                    out_col_reg <= oc1;
                    out_row_reg <= or1;
                end
            end
        end
    end

    // stage 1: line store read; the incoming pixel and address are held
    logic [rcz_pkg::PIX_BITS-1:0] pix;
    assign pix = s_drain ? '0 : {s_blue_in, s_green_in, s_red_in};

    logic [rcz_pkg::PIX_BITS-1:0] upper_rd, lower_rd;
    logic [rcz_pkg::PIX_BITS-1:0] pix_s1_reg;
    logic [AW-1:0]                addr_s1_reg;
    rcz_pkg::tag_t                tag_s1_reg, tag_s2_reg, tag_s3_reg;
    logic                         fire_s1_reg;

    // forwarding for width one, where the same column is read every transfer
    logic                         fw_hit_reg;
    logic [rcz_pkg::PIX_BITS-1:0] fw_upper_reg, fw_lower_reg;
    logic [rcz_pkg::PIX_BITS-1:0] upper_fw, lower_fw;
    assign upper_fw = fw_hit_reg ? fw_upper_reg : upper_rd;
    assign lower_fw = fw_hit_reg ? fw_lower_reg : lower_rd;

    // write-back happens from the stage-1 registers, once the read data is seen;
    // a read of the same column during that write-back is forwarded
    logic wb_en;
    assign wb_en = fire_s1_reg && adv;

    rcz_ram #(.WIDTH(rcz_pkg::PIX_BITS), .DEPTH(MAX_WIDTH)) u_upper (
        .aclk    (aclk),
        .wr_en   (wb_en),
        .wr_addr (addr_s1_reg),
        .wr_data (lower_fw),
        .rd_en   (s_fire),
        .rd_addr (ic0[AW-1:0]),
        .rd_data (upper_rd)
    );
    rcz_ram #(.WIDTH(rcz_pkg::PIX_BITS), .DEPTH(MAX_WIDTH)) u_lower (
        .aclk    (aclk),
        .wr_en   (wb_en),
        .wr_addr (addr_s1_reg),
        .wr_data (pix_s1_reg),
        .rd_en   (s_fire),
        .rd_addr (ic0[AW-1:0]),
        .rd_data (lower_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fire_s1_reg <= 1'b0;
            tag_s1_reg  <= '0;
            tag_s2_reg  <= '0;
            tag_s3_reg  <= '0;
            fw_hit_reg  <= 1'b0;
        end else if (adv) begin
            fire_s1_reg <= s_fire;
            tag_s1_reg  <= '{valid: s_fire && emit, row_ok: row_ok, col_ok: col_ok,
                             last: last};
            tag_s2_reg  <= tag_s1_reg;
            tag_s3_reg  <= tag_s2_reg;
            fw_hit_reg  <= s_fire && fire_s1_reg && (ic0[AW-1:0] == addr_s1_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (s_fire) begin
                pix_s1_reg  <= pix;
                addr_s1_reg <= ic0[AW-1:0];
            end
            fw_upper_reg <= lower_fw;
            fw_lower_reg <= pix_s1_reg;
        end
    end

    // chain of three cells: new column enters cell 2 and shifts toward cell 0
    rcz_pkg::column_t col_new, col_c2, col_c1;
    assign col_new = '{top: upper_fw, mid: lower_fw, bot: pix_s1_reg};

    logic signed [rcz_pkg::SUM_BITS-1:0] part [3][3];
    logic shift_en;
    assign shift_en = wb_en;

    // the window shifts as stage 1 advances; the cells multiply the shifted
    // window as stage 2 advances, so their masks come from the stage-2 tag
    rcz_cell u_cell2 (
        .aclk(aclk), .shift_en(shift_en), .mul_en(adv), .col_in(col_new), .col_out(col_c2),
        .row_ok(tag_s2_reg.row_ok), .col_ok(tag_s2_reg.col_ok[2]),
        .tap_top(ktop_reg[47:32]), .tap_mid(kmid_reg[47:32]), .tap_bot(kbot_reg[47:32]),
        .part_sum(part[2])
    );
    rcz_cell u_cell1 (
        .aclk(aclk), .shift_en(shift_en), .mul_en(adv), .col_in(col_c2), .col_out(col_c1),
        .row_ok(tag_s2_reg.row_ok), .col_ok(tag_s2_reg.col_ok[1]),
        .tap_top(ktop_reg[31:16]), .tap_mid(kmid_reg[31:16]), .tap_bot(kbot_reg[31:16]),
        .part_sum(part[1])
    );
    rcz_cell u_cell0 (
        .aclk(aclk), .shift_en(shift_en), .mul_en(adv), .col_in(col_c1), .col_out(),
        .row_ok(tag_s2_reg.row_ok), .col_ok(tag_s2_reg.col_ok[0]),
        .tap_top(ktop_reg[15:0]), .tap_mid(kmid_reg[15:0]), .tap_bot(kbot_reg[15:0]),
        .part_sum(part[0])
    );

    // last stage: sum the cell partials, clamp, hold in the output register
    logic [7:0] res_reg [3];
    logic       m_valid_reg, last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= tag_s3_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int ch = 0; ch < 3; ch++)
                res_reg[ch] <= rcz_pkg::clamp_channel(part[0][ch] + part[1][ch] + part[2][ch],
                                                      COEF_FRAC_BITS);
            last_reg <= tag_s3_reg.last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_out   = res_reg[0];
    assign m_green_out = res_reg[1];
    assign m_blue_out  = res_reg[2];
    assign m_frame_end = last_reg && m_valid_reg;

    // a stalled result holds its tag until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped during stall");
    // nothing enters while the result register is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("transfer taken while stalled");
    // the output column counter stays within MAX_WIDTH while the width is unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        $stable(width_cfg_reg) |-> out_col_reg <= CW'(MAX_WIDTH))
        else $error("output column out of range");
endmodule

// ===== tb/rgb_conv3x3_zero_pad_test.sv =====
// testbench for the rgb 3x3 zero-padded convolution: predicts each result and checks it
`timescale 1ns / 100ps

module rgb_conv3x3_zero_pad_test;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } pixel_result_t;

    localparam int STALL_LIMIT = 5000;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               cfg_we = 1'b0;
    logic [rcz_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [rcz_pkg::CFG_WIDTH-1:0]      cfg_data = '0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic [7:0]                         s_red_in = '0;
    logic [7:0]                         s_green_in = '0;
    logic [7:0]                         s_blue_in = '0;
    logic                               s_drain = 1'b0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic [7:0]                         m_red_out;
    logic [7:0]                         m_green_out;
    logic [7:0]                         m_blue_out;
    logic                               m_frame_end;

    // shadow copy of the registers and the block state
    logic [10:0]                   width_reg;
    logic [15:0]                   height_reg;
    logic [rcz_pkg::CFG_WIDTH-1:0] kernel_rows [3];
    logic [23:0]                   upper_line [rcz_pkg::MAX_WIDTH];
    logic [23:0]                   lower_line [rcz_pkg::MAX_WIDTH];
    logic [23:0]                   window [9];
    int unsigned                   in_col, in_row, out_col, out_row;

    pixel_result_t expected_pixels [$];
    int  error_count = 0;
    int  stall_cycles = 0;
    bit  idle_enabled = 1'b1;
    bit  timed_out = 1'b0;

    rgb_conv3x3_zero_pad uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_red_in(s_red_in), .s_green_in(s_green_in), .s_blue_in(s_blue_in),
        .s_drain(s_drain),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red_out(m_red_out), .m_green_out(m_green_out), .m_blue_out(m_blue_out),
        .m_frame_end(m_frame_end)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > rcz_pkg::MAX_WIDTH) return rcz_pkg::MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // advance the shadow state by one transfer and queue the result it causes
    task automatic convolve_pixel(input logic [23:0] pix_in, input logic drain);
        int unsigned   w, h, col;
        logic [23:0]   pix;
        bit            emit, last;
        bit            row_ok [3];
        bit            col_ok [3];
        int            sum, tap;
        pixel_result_t res;
        logic [7:0]    chan [3];
        begin
            w = eff_width();
            h = eff_height();
            if (in_col >= w) begin
                in_col = 0;
                if (in_row < 'h1FFFF) in_row++;
            end
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
            pix = drain ? 24'd0 : pix_in;
            col = in_col;
            for (int r = 0; r < 3; r++) begin
                window[r*3]   = window[r*3+1];
                window[r*3+1] = window[r*3+2];
            end
            window[2] = upper_line[col];
            window[5] = lower_line[col];
            window[8] = pix;
            upper_line[col] = lower_line[col];
            lower_line[col] = pix;
            emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                if (in_row < 'h1FFFF) in_row++;
            end
            if (emit) begin
                row_ok[0] = out_row > 0;
                row_ok[1] = 1'b1;
                row_ok[2] = out_row + 1 < h;
                col_ok[0] = out_col > 0;
                col_ok[1] = 1'b1;
                col_ok[2] = out_col + 1 < w;
                for (int ch = 0; ch < 3; ch++) begin
                    sum = 0;
                    for (int r = 0; r < 3; r++)
                        for (int c = 0; c < 3; c++)
                            if (row_ok[r] && col_ok[c]) begin
                                tap = $signed(kernel_rows[r][16*c +: 16]);
                                sum += int'(window[r*3+c][8*ch +: 8]) * tap;
                            end
                    if (sum < 0) chan[ch] = 8'd0;
                    else if ((sum >>> rcz_pkg::COEF_FRAC_BITS) > 255) chan[ch] = 8'd255;
                    else chan[ch] = 8'(sum >>> rcz_pkg::COEF_FRAC_BITS);
                end
                last = (out_row + 1 >= h) && (out_col + 1 >= w);
                res.red = chan[0];
                res.green = chan[1];
                res.blue = chan[2];
                res.frame_end = last;
                expected_pixels.push_back(res);
                if (last) begin
                    in_col = 0;
                    in_row = 0;
                    out_col = 0;
                    out_row = 0;
                end else begin
                    out_col++;
                    if (out_col >= w) begin
                        out_col = 0;
                        out_row++;
                    end
                end
            end
        end
    endtask

    // one input transfer; valid drops only during random idle cycles
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic drain);
        begin
            while (idle_enabled && $urandom_range(99) < 11) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid    <= 1'b1;
            s_red_in   <= r;
            s_green_in <= g;
            s_blue_in  <= b;
            s_drain    <= drain;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            convolve_pixel({b, g, r}, drain);
        end
    endtask

    // drop valid and let the pipeline empty before touching registers
    task automatic wait_idle();
        begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while (expected_pixels.size() != 0) @(posedge aclk);
            repeat (10) @(posedge aclk);
        end
    endtask

    // the caller drops cfg_we after its last write
    task automatic write_reg(input logic [rcz_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [rcz_pkg::CFG_WIDTH-1:0] value);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge aclk);
            case (idx)
                rcz_pkg::REG_IMAGE_WIDTH:   width_reg = value[10:0];
                rcz_pkg::REG_IMAGE_HEIGHT:  height_reg = value[15:0];
                rcz_pkg::REG_KERNEL_TOP:    kernel_rows[0] = value;
                rcz_pkg::REG_KERNEL_MIDDLE: kernel_rows[1] = value;
                rcz_pkg::REG_KERNEL_BOTTOM: kernel_rows[2] = value;
                default: ;
            endcase
        end
    endtask

    task automatic set_geometry(input logic [10:0] w, input logic [15:0] h,
                                input logic [rcz_pkg::CFG_WIDTH-1:0] top,
                                input logic [rcz_pkg::CFG_WIDTH-1:0] mid,
                                input logic [rcz_pkg::CFG_WIDTH-1:0] bot);
        begin
            wait_idle();
            write_reg(rcz_pkg::REG_IMAGE_WIDTH, rcz_pkg::CFG_WIDTH'(w));
            write_reg(rcz_pkg::REG_IMAGE_HEIGHT, rcz_pkg::CFG_WIDTH'(h));
            write_reg(rcz_pkg::REG_KERNEL_TOP, top);
            write_reg(rcz_pkg::REG_KERNEL_MIDDLE, mid);
            write_reg(rcz_pkg::REG_KERNEL_BOTTOM, bot);
            cfg_we <= 1'b0;
        end
    endtask

    // whole frame plus the width+1 flush transfers; flush pixels sometimes carry data
    task automatic send_frame(input bit extreme_pixels);
        int unsigned w, h;
        logic [7:0]  r, g, b;
        begin
            w = eff_width();
            h = eff_height();
            for (int unsigned i = 0; i < w * h + w + 1; i++) begin
                if (extreme_pixels) begin
                    r = $urandom_range(1) ? 8'hFF : 8'h00;
                    g = $urandom_range(1) ? 8'hFF : 8'h00;
                    b = $urandom_range(1) ? 8'hFF : 8'h00;
                end else begin
                    r = 8'($urandom);
                    g = 8'($urandom);
                    b = 8'($urandom);
                end
                if (i < w * h)
                    send_pixel(r, g, b, $urandom_range(19) == 0);
                else
                    send_pixel(r, g, b, $urandom_range(3) != 0);
            end
        end
    endtask

    function automatic logic [rcz_pkg::CFG_WIDTH-1:0] random_kernel_row();
        logic [rcz_pkg::CFG_WIDTH-1:0] row;
        begin
            row = rcz_pkg::CFG_WIDTH'({$urandom, $urandom});
            if ($urandom_range(3) != 0)
                for (int c = 0; c < 3; c++)
                    row[16*c +: 16] = 16'($signed($urandom_range(640)) - 320);
            return row;
        end
    endfunction

    // extreme taps and saturating pixels on a small frame, drain mixed in
    task automatic test_directed_extremes();
        begin
            set_geometry(11'd4, 16'd3, 48'h8000_7FFF_0100, 48'h0080_FF00_7FFF,
                         48'h0000_8000_FFFF);
            send_frame(1'b1);
        end
    endtask

    // identity kernel, zero geometry, single row and single column frames
    task automatic test_geometry_limits();
        begin
            set_geometry(11'd0, 16'd0, 48'h0, 48'h0000_0100_0000, 48'h0);
            send_frame(1'b0);
            set_geometry(11'd3, 16'd0, 48'h0100_0100_0100, 48'h0100_0100_0100,
                         48'h0100_0100_0100);
            send_frame(1'b0);
            set_geometry(11'd5, 16'd1, 48'hFFFF_FFFF_FFFF, 48'h0040_0040_0040,
                         48'h8000_8000_8000);
            send_frame(1'b1);
            set_geometry(11'd1, 16'd7, 48'h0000_0200_0000, 48'h0000_0080_0000,
                         48'h0000_0100_0000);
            send_frame(1'b0);
        end
    endtask

    // random small frames and kernels; every fifth frame runs without idling, one full drain pause
    task automatic test_random_frames();
        int sent;
        int frame_no;
        begin
            sent = 0;
            frame_no = 0;
            while (sent < 455) begin
                set_geometry(11'($urandom_range(8, 1)), 16'($urandom_range(6, 1)),
                             random_kernel_row(), random_kernel_row(), random_kernel_row());
                idle_enabled = (frame_no % 5) != 2;
                send_frame(1'b0);
                sent += eff_width() * eff_height() + eff_width() + 1;
                if (frame_no == 3) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (expected_pixels.size() != 0) @(posedge aclk);
                end
                frame_no++;
            end
            idle_enabled = 1'b1;
        end
    endtask

    // result side: random back-pressure, checking and the watchdog
    always @(posedge aclk) begin
        pixel_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= (idle_enabled == 1'b0) || ($urandom_range(99) >= 11);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t unexpected transfer: actual %h %h %h %b", $time,
                             m_red_out, m_green_out, m_blue_out, m_frame_end);
                    error_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_red_out !== want.red) begin
                        $display("%0t red expected %h actual %h", $time, want.red, m_red_out);
                        error_count++;
                    end
                    if (m_green_out !== want.green) begin
                        $display("%0t green expected %h actual %h", $time, want.green,
                                 m_green_out);
                        error_count++;
                    end
                    if (m_blue_out !== want.blue) begin
                        $display("%0t blue expected %h actual %h", $time, want.blue,
                                 m_blue_out);
                        error_count++;
                    end
                    if (m_frame_end !== want.frame_end) begin
                        $display("%0t frame_end expected %b actual %b", $time,
                                 want.frame_end, m_frame_end);
                        error_count++;
                    end
                end
            end
            if (stall_cycles >= STALL_LIMIT && !timed_out) begin
                timed_out = 1'b1;
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        width_reg = 11'd1024;
        height_reg = 16'd1024;
        kernel_rows[0] = '0;
        kernel_rows[1] = 48'h0000_0100_0000;
        kernel_rows[2] = '0;
        for (int i = 0; i < rcz_pkg::MAX_WIDTH; i++) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        for (int i = 0; i < 9; i++) window[i] = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_extremes();
        test_geometry_limits();
        test_random_frames();

        // final drain of outstanding results
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
